@@ sv/cwpc_pkg.sv @@
// Package for the camera window pixel capture unit.
// Holds the payload structs, the window settings, and the register and result codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwpc_pkg;

   // Buffer size and counter limits.
   localparam int unsigned MAX_CAPTURE = 4096;
   localparam int unsigned ROW_W       = 10;
   localparam int unsigned COL_W       = 11;
   localparam int unsigned INDEX_W     = 12;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [ROW_W-1:0]   ROW_LIMIT = 10'd1023;
   localparam logic [COL_W-1:0]   COL_LIMIT = 11'd2047;
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CAPTURE);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_ROW    = 2'd0,
      CSR_ROW_TOTAL    = 2'd1,
      CSR_FIRST_COLUMN = 2'd2,
      CSR_COLUMN_TOTAL = 2'd3
   } csr_index_type;

   // Result kinds.
   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_DONE  = 1'b1
   } kind_type;

   typedef struct packed {
      logic       arm;
      logic       frame_sync;
      logic       line_valid;
      logic       pixel_clock;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         captured_byte;
      logic [INDEX_W-1:0] capture_index;
      logic [COUNT_W-1:0] capture_count;
   } rsp_type;

   // Capture window settings.
   typedef struct packed {
      logic [ROW_W-1:0] first_row;
      logic [ROW_W-1:0] row_total;
      logic [COL_W-1:0] first_column;
      logic [COL_W-1:0] column_total;
   } window_type;

endpackage

`default_nettype wire

@@ sv/camera_window_pixel_capture_unit.sv @@
// Camera window pixel capture unit: top level with window registers and result buffering.
// A result enters the output register, or the skid register while that one is held.
// Throughput: one sample per cycle; an output register plus a skid register keep
// samples flowing while a result waits, and req_ready drops only when both are full.
// Reset (synchronous, active high) idles the engine, empties the buffers and loads
// the window defaults: first row 0, 200 rows, first column 99, 2 columns.
`timescale 1ns / 1ps
`default_nettype none

module camera_window_pixel_capture_unit
   import cwpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   window_type window_ff;
   logic       out_valid_ff;
   rsp_type    out_data_ff;
   logic       skid_valid_ff;
   rsp_type    skid_data_ff;

   logic       step;
   logic       new_valid;
   rsp_type    new_data;
   logic       rsp_transfer;

   assign req_ready    = !skid_valid_ff;
   assign step         = req_valid && req_ready;
   assign rsp_transfer = out_valid_ff && rsp_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_data_ff;

   // Window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.first_row    <= ROW_W'(0);
         window_ff.row_total    <= ROW_W'(200);
         window_ff.first_column <= COL_W'(99);
         window_ff.column_total <= COL_W'(2);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FIRST_ROW:    window_ff.first_row    <= csr_write_data[ROW_W-1:0];
            CSR_ROW_TOTAL:    window_ff.row_total    <= csr_write_data[ROW_W-1:0];
            CSR_FIRST_COLUMN: window_ff.first_column <= csr_write_data[COL_W-1:0];
            CSR_COLUMN_TOTAL: window_ff.column_total <= csr_write_data[COL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cwpc_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (req_data),
      .window       (window_ff),
      .result_valid (new_valid),
      .result       (new_data)
   );

   // Output register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_transfer) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (step && new_valid) begin
            if (!out_valid_ff || rsp_transfer) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_transfer) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_transfer) out_data_ff <= skid_data_ff;
      end else if (step && new_valid) begin
         if (!out_valid_ff || rsp_transfer) begin
            out_data_ff <= new_data;
         end else begin
            skid_data_ff <= new_data;
         end
      end
   end

   // The skid stage only fills behind a waiting result.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   // The reported count never passes the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.capture_count <= COUNT_MAX)
      else $error("capture count beyond buffer size");

   // A captured pixel's count is its index plus one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_PIXEL) |->
         rsp_data.capture_count == ({1'b0, rsp_data.capture_index} + COUNT_W'(1)))
      else $error("pixel count does not follow its index");

endmodule

`default_nettype wire

@@ sv/cwpc_engine.sv @@
// Capture engine: frame sync tracking, edge detection, row and column counting.
// Produces at most one result per transferred sample. Depends on cwpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwpc_engine
   import cwpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire req_type    item,
   input  wire window_type window,
   output logic            result_valid,
   output rsp_type         result
);

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_WAIT_HIGH = 2'd1,
      PH_WAIT_LOW  = 2'd2,
      PH_CAPTURE   = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               last_lv_ff;
   logic               last_pc_ff;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;

   logic               lv_fall;
   logic               pc_fall;
   logic [ROW_W:0]     row_end;
   logic [ROW_W:0]     row_ended;
   logic [COL_W:0]     col_end;
   logic               row_in_window;
   logic               col_in_window;

   // Window bounds, one bit wider so the sums never wrap.
   assign row_end   = {1'b0, window.first_row} + {1'b0, window.row_total};
   assign col_end   = {1'b0, window.first_column} + {1'b0, window.column_total};
   assign row_ended = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign lv_fall   = last_lv_ff && !item.line_valid;
   assign pc_fall   = last_pc_ff && !item.pixel_clock;

   assign row_in_window = (row_ff >= window.first_row) && ({1'b0, row_ff} < row_end);
   assign col_in_window = (col_ff >= window.first_column) && ({1'b0, col_ff} < col_end);

   // Next state and result for the sample at the input.
   always_comb begin
      phase_in     = phase_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      bytes_in     = bytes_ff;
      result_valid = 1'b0;
      result       = '0;
      if (item.arm) begin
         phase_in = PH_WAIT_HIGH;
         row_in   = '0;
         col_in   = '0;
         bytes_in = '0;
      end else begin
         case (phase_ff)
            PH_WAIT_HIGH: begin
               if (item.frame_sync) phase_in = PH_WAIT_LOW;
            end
            PH_WAIT_LOW: begin
               if (!item.frame_sync) phase_in = PH_CAPTURE;
            end
            PH_CAPTURE: begin
               if (lv_fall) begin
                  // End of a row: finish after the last window row or at the counter limit.
                  col_in = '0;
                  if (row_ended >= row_end || row_ff >= ROW_LIMIT) begin
                     phase_in             = PH_IDLE;
                     result_valid         = 1'b1;
                     result.kind          = KIND_DONE;
                     result.capture_count = bytes_ff;
                  end else begin
                     row_in = row_ended[ROW_W-1:0];
                  end
               end else if (item.line_valid && pc_fall && col_ff < COL_LIMIT) begin
                  // Pixel edge inside a row; capture when inside the window and room is left.
                  col_in = col_ff + COL_W'(1);
                  if (row_in_window && col_in_window && bytes_ff < COUNT_MAX) begin
                     bytes_in             = bytes_ff + COUNT_W'(1);
                     result_valid         = 1'b1;
                     result.kind          = KIND_PIXEL;
                     result.captured_byte = item.pixel_byte;
                     result.capture_index = bytes_ff[INDEX_W-1:0];
                     result.capture_count = bytes_ff + COUNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Engine state advances on each sample transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         last_lv_ff <= 1'b0;
         last_pc_ff <= 1'b0;
         row_ff     <= '0;
         col_ff     <= '0;
         bytes_ff   <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         last_lv_ff <= item.line_valid;
         last_pc_ff <= item.pixel_clock;
         row_ff     <= row_in;
         col_ff     <= col_in;
         bytes_ff   <= bytes_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/camera_window_pixel_capture_unit_test.sv @@
// Testbench for the camera window pixel capture unit: camera port samples in, pixels out.
// A directed table, then randomized frames under several idle and stall patterns.
// Depends on cwpc_pkg and camera_window_pixel_capture_unit.
`timescale 1ns / 1ps

module camera_window_pixel_capture_unit_test;
   import cwpc_pkg::*;

   // Sync tracking of the capture engine as the testbench mirrors it.
   typedef enum logic [1:0] {
      SYNC_IDLE      = 2'd0,
      SYNC_WAIT_HIGH = 2'd1,
      SYNC_WAIT_LOW  = 2'd2,
      SYNC_CAPTURE   = 2'd3
   } sync_phase_t;

   // One row of the directed table: the port sample and, where it is obvious,
   // the result that it must cause.
   typedef struct packed {
      req_type pins;
      logic    has_fixed;
      rsp_type fixed_rsp;
   } directed_row_t;

   localparam rsp_type NO_RSP = '0;
   localparam int DIRECTED_COUNT = 26;
   localparam int PHASE_ITEMS = 175;
   localparam int HOLD_CYCLES = 300;
   localparam int unsigned IDLE_PCT [4] = '{0, 74, 0, 29};
   localparam int unsigned STALL_PCT [4] = '{0, 0, 74, 29};

   // Window used by the table: rows 1 to 1, edges 0 to 1.
   // Fields: arm, frame sync, line valid, pixel clock, byte, fixed, result.
   localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Idle sample without arm, then arm and frame sync high then low.
      {1'b0, 1'b1, 1'b1, 1'b1, 8'hff, 1'b0, NO_RSP},
      {1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b1, 1'b0, 1'b0, 8'h12, 1'b0, NO_RSP},
      {1'b0, 1'b1, 1'b0, 1'b1, 8'h34, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b1, 1'b1, 8'h56, 1'b0, NO_RSP},
      // Falling pixel clock on the first capturing sample, outside the window.
      {1'b0, 1'b0, 1'b1, 1'b0, 8'hff, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      // Row 1 lies in the window: two bytes, then one past the last column.
      {1'b0, 1'b0, 1'b1, 1'b1, 8'h81, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, KIND_PIXEL, 8'h00, 12'd0, 13'd1},
      {1'b0, 1'b0, 1'b1, 1'b1, 8'h7e, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b1, 1'b0, 8'hff, 1'b1, KIND_PIXEL, 8'hff, 12'd1, 13'd2},
      {1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b1, 1'b0, 8'h5a, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b0, 1'b1, 8'hc3, 1'b1, KIND_DONE, 8'h00, 12'd0, 13'd2},
      // Back in idle a pixel edge is ignored.
      {1'b0, 1'b0, 1'b1, 1'b0, 8'h3c, 1'b0, NO_RSP},
      // Arming again while waiting for frame sync low restarts the wait.
      {1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      // Frame sync is ignored while capturing; a line end beats a pixel edge.
      {1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b1, 1'b1, 1'b0, 8'h33, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b1, 1'b1, 8'ha5, 1'b0, NO_RSP},
      {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, KIND_DONE, 8'h00, 12'd0, 13'd0}
   };

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // Mirror of the block's window registers and capture state.
   window_type         capture_window = {10'd0, 10'd200, 11'd99, 11'd2};
   sync_phase_t        sync_phase = SYNC_IDLE;
   logic               prev_line_valid = 1'b0;
   logic               prev_pixel_clock = 1'b0;
   logic [ROW_W-1:0]   row_count = '0;
   logic [COL_W-1:0]   column_count = '0;
   logic [COUNT_W-1:0] stored_bytes = '0;

   rsp_type     capture_results_due [$];
   int unsigned mismatch_count = 0;
   int unsigned samples_sent = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned noise_pct = 0;
   bit          hold_request = 1'b0;

   camera_window_pixel_capture_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the mirrored capture engine by one port sample.
   function automatic void advance_capture(input req_type s, output bit produced,
                                           output rsp_type r);
      logic had_line;
      logic had_clock;
      int   first_row;
      int   last_row;
      int   column;
      had_line = prev_line_valid;
      had_clock = prev_pixel_clock;
      first_row = int'(capture_window.first_row);
      last_row = first_row + int'(capture_window.row_total);
      column = int'(column_count);
      produced = 1'b0;
      r = '0;
      prev_line_valid = s.line_valid;
      prev_pixel_clock = s.pixel_clock;
      if (s.arm) begin
         sync_phase = SYNC_WAIT_HIGH;
         row_count = '0;
         column_count = '0;
         stored_bytes = '0;
      end else begin
         case (sync_phase)
            SYNC_WAIT_HIGH: begin
               if (s.frame_sync) sync_phase = SYNC_WAIT_LOW;
            end
            SYNC_WAIT_LOW: begin
               if (!s.frame_sync) sync_phase = SYNC_CAPTURE;
            end
            SYNC_CAPTURE: begin
               if (had_line && !s.line_valid) begin
                  // End of a row; the last window row or the row limit finishes.
                  column_count = '0;
                  if (int'(row_count) + 1 >= last_row || row_count >= ROW_LIMIT) begin
                     produced = 1'b1;
                     r.kind = KIND_DONE;
                     r.capture_count = stored_bytes;
                     sync_phase = SYNC_IDLE;
                  end else begin
                     row_count = row_count + 1'b1;
                  end
               end else if (s.line_valid && had_clock && !s.pixel_clock &&
                            column_count < COL_LIMIT) begin
                  if (int'(row_count) >= first_row && int'(row_count) < last_row &&
                      column >= int'(capture_window.first_column) &&
                      column < int'(capture_window.first_column) +
                               int'(capture_window.column_total) &&
                      stored_bytes < COUNT_MAX) begin
                     produced = 1'b1;
                     r.kind = KIND_PIXEL;
                     r.captured_byte = s.pixel_byte;
                     r.capture_index = stored_bytes[INDEX_W-1:0];
                     r.capture_count = stored_bytes + 1'b1;
                     stored_bytes = stored_bytes + 1'b1;
                  end
                  column_count = column_count + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   endfunction

   function automatic void compare_field(input string what, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // Offer one sample, wait for its transfer and note what it must cause.
   task automatic drive_sample(input req_type s, input bit has_fixed,
                               input rsp_type fixed_rsp);
      bit      produced;
      rsp_type predicted;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      advance_capture(s, produced, predicted);
      if (has_fixed) capture_results_due.push_back(fixed_rsp);
      else if (produced) capture_results_due.push_back(predicted);
      samples_sent++;
   endtask

   // Drive the port pins, replaced by random pins at the current noise rate.
   task automatic drive_camera(input logic arm, input logic frame_sync,
                               input logic line_valid, input logic pixel_clock,
                               input logic [7:0] pixel_byte);
      req_type s;
      s.arm = arm;
      s.frame_sync = frame_sync;
      s.line_valid = line_valid;
      s.pixel_clock = pixel_clock;
      s.pixel_byte = pixel_byte;
      if ($urandom_range(99) < noise_pct) begin
         {s.frame_sync, s.line_valid, s.pixel_clock, s.pixel_byte} = 11'($urandom);
         s.arm = ($urandom_range(15) == 0);
      end
      drive_sample(s, 1'b0, NO_RSP);
   endtask

   // Arm, frame sync pulse, then rows of pixel clock cycles; rows below
   // plain_rows carry no pixel edges.
   task automatic send_frame(input int rows, input int edges, input int plain_rows);
      drive_camera(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      repeat ($urandom_range(2)) drive_camera(1'b0, 1'b0, 1'b0, 1'($urandom), 8'($urandom));
      repeat ($urandom_range(3, 1))
         drive_camera(1'b0, 1'b1, 1'b0, 1'($urandom), 8'($urandom));
      drive_camera(1'b0, 1'b0, 1'b0, 1'($urandom), 8'($urandom));
      for (int r = 0; r < rows; r++) begin
         drive_camera(1'b0, 1'($urandom), 1'b1, 1'b0, 8'($urandom));
         if (r >= plain_rows) begin
            for (int e = 0; e < edges; e++) begin
               drive_camera(1'b0, 1'($urandom), 1'b1, 1'b1, 8'($urandom));
               drive_camera(1'b0, 1'($urandom), 1'b1, 1'b0, 8'($urandom));
            end
         end
         drive_camera(1'b0, 1'($urandom), 1'b0, 1'($urandom), 8'($urandom));
         repeat ($urandom_range(2))
            drive_camera(1'b0, 1'($urandom), 1'b0, 1'($urandom), 8'($urandom));
      end
   endtask

   // Stop offering and let every outstanding result come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (capture_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four window registers on consecutive cycles.
   task automatic load_window(input window_type w);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FIRST_ROW;
      csr_write_data <= CSR_DATA_W'(w.first_row);
      @(posedge clock);
      csr_index <= CSR_ROW_TOTAL;
      csr_write_data <= CSR_DATA_W'(w.row_total);
      @(posedge clock);
      csr_index <= CSR_FIRST_COLUMN;
      csr_write_data <= w.first_column;
      @(posedge clock);
      csr_index <= CSR_COLUMN_TOTAL;
      csr_write_data <= w.column_total;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capture_window = w;
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   initial begin : result_receiver
      int remaining;
      remaining = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            remaining = HOLD_CYCLES;
         end
         if (remaining > 0) begin
            remaining--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (capture_results_due.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            due = capture_results_due.pop_front();
            compare_field("kind", due.kind, rsp_data.kind);
            compare_field("captured_byte", due.captured_byte, rsp_data.captured_byte);
            compare_field("capture_index", due.capture_index, rsp_data.capture_index);
            compare_field("capture_count", due.capture_count, rsp_data.capture_count);
         end
      end
   end

   initial begin : stimulus
      window_type w;
      int         rows;
      int         edges;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_FIRST_ROW;
      csr_write_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      load_window({10'd1, 10'd1, 11'd0, 11'd2});
      for (int i = 0; i < DIRECTED_COUNT; i++)
         drive_sample(DIRECTED_ROWS[i].pins, DIRECTED_ROWS[i].has_fixed,
                      DIRECTED_ROWS[i].fixed_rsp);

      // Random frames over small windows, one idling pattern per phase.
      for (int p = 0; p < 4; p++) begin
         idle_pct = IDLE_PCT[p];
         stall_pct = STALL_PCT[p];
         while (samples_sent < DIRECTED_COUNT + (p + 1) * PHASE_ITEMS) begin
            noise_pct = ($urandom_range(2) == 0) ? 10 : 0;
            w.first_row = 10'($urandom_range(3));
            w.row_total = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom_range(4, 1));
            w.first_column = 11'($urandom_range(6));
            w.column_total = ($urandom_range(7) == 0) ? 11'd0 : 11'($urandom_range(6, 1));
            rows = int'(w.first_row) + ((w.row_total == 10'd0) ? 1 : int'(w.row_total));
            if ($urandom_range(9) == 0) rows = $urandom_range(rows);
            edges = int'(w.first_column) + int'(w.column_total) + $urandom_range(2);
            if ($urandom_range(4) == 0) edges = $urandom_range(edges);
            wait_for_results();
            load_window(w);
            send_frame(rows, edges, 0);
         end
      end
      idle_pct = 0;
      stall_pct = 0;
      noise_pct = 0;

      // A wide window while the receiver holds off and the sender keeps
      // offering, so the result buffers fill and the input stalls.
      wait_for_results();
      load_window({10'd0, 10'd3, 11'd0, 11'd20});
      hold_request = 1'b1;
      send_frame(3, 20, 0);

      // Empty window at the far column ends on the first row.
      wait_for_results();
      load_window({10'd0, 10'd0, 11'd2047, 11'd0});
      send_frame(2, 6, 0);

      wait_for_results();
      if (mismatch_count == 0 && capture_results_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #(10_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sim.f @@
sv/cwpc_pkg.sv
sv/cwpc_engine.sv
sv/camera_window_pixel_capture_unit.sv
tb/camera_window_pixel_capture_unit_test.sv
